// ===== hw/rtl/dlpa_pkg.sv =====
// shared types and constants for the die link path allocator
package dlpa_pkg;

  localparam int DIES_DEF       = 4;
  localparam int POINT_BITS_DEF = 16;
  localparam int PACKED_DIES    = 4;
  localparam int CAP_BITS       = 16;
  localparam int MAX_LEN        = 4;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 64;
  localparam logic [CAP_BITS-1:0] NO_RELAY = '1;

  localparam logic [CFG_IDX_BITS-1:0] REG_CAP0  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CAP3  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_RELAY = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAXP  = 3'd5;

  localparam logic [1:0] ST_ROUTED  = 2'd0;
  localparam logic [1:0] ST_SAME    = 2'd1;
  localparam logic [1:0] ST_NO_PATH = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_COMMIT,
    S_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic same;
    logic done;
  } dp_stat_t;

endpackage

// ===== hw/rtl/dlpa_ctrl.sv =====
// controller state machine: accept, search, commit, present
module dlpa_ctrl import dlpa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_fire,
  input  logic     out_fire,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     in_ready,
  output logic     out_valid
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_fire) state_next = S_SEARCH;
      S_SEARCH: begin
        if (stat.same)      state_next = S_OUT;
        else if (stat.done) state_next = S_COMMIT;
      end
      S_COMMIT: state_next = S_OUT;
      S_OUT:    if (out_fire) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      S_IDLE:   begin in_ready = 1'b1; cmd.load = in_fire; end
      S_SEARCH: cmd.step = ~stat.same & ~stat.done;
      S_COMMIT: cmd.commit = 1'b1;
      S_OUT:    out_valid = 1'b1;
      default:  ;
    endcase
  end

endmodule

// ===== hw/rtl/dlpa_datapath.sv =====
// datapath: config registers, usage counters, candidate path walk
module dlpa_datapath import dlpa_pkg::*; #(
  parameter int DIES       = DIES_DEF,
  parameter int POINT_BITS = POINT_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  dp_cmd_t                  cmd,
  output dp_stat_t                 stat,
  input  logic [1:0]               in_src,
  input  logic [1:0]               in_dst,
  input  logic [POINT_BITS-1:0]    in_s,
  input  logic [POINT_BITS-1:0]    in_l,
  output logic [1:0]               status,
  output logic [15:0]              source_point,
  output logic [15:0]              dest_point,
  output logic [2:0]               path_length,
  output logic [1:0]               second_die,
  output logic [1:0]               third_die,
  output logic [1:0]               fourth_die,
  output logic [15:0]              first_relay,
  output logic [15:0]              second_relay
);

  localparam int NL = PACKED_DIES * PACKED_DIES;

  logic [CFG_DATA_BITS-1:0] cap [PACKED_DIES];
  logic [CFG_DATA_BITS-1:0] relay_pts;
  logic [2:0]               max_dies;
  logic [CAP_BITS-1:0]      usage [NL];

  logic [1:0] src, dst;
  logic [4:0] cand; // enumerates len 2..4 candidates: index over (len, m1, m2)
  logic [1:0] m1, m2;
  logic [2:0] len;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PACKED_DIES; i++) cap[i] <= '0;
      relay_pts <= '1;
      max_dies <= 3'd4;
    end else if (cfg_we) begin
      if (cfg_index <= REG_CAP3) cap[cfg_index[1:0]] <= cfg_data;
      else if (cfg_index == REG_RELAY) relay_pts <= cfg_data;
      else if (cfg_index == REG_MAXP) max_dies <= cfg_data[2:0];
    end
  end

  function automatic logic valid_die(input logic [1:0] d);
    return 32'(d) < DIES;
  endfunction

  function automatic logic [CAP_BITS-1:0] capf(input logic [1:0] a, input logic [1:0] b);
    if (!valid_die(a) || !valid_die(b) || a == b) return '0;
    return cap[a][16*b +: 16];
  endfunction

  function automatic logic [CAP_BITS-1:0] relf(input logic [1:0] d);
    if (!valid_die(d)) return NO_RELAY;
    return relay_pts[16*d +: 16];
  endfunction

  function automatic logic link_ok(input logic [1:0] a, input logic [1:0] b);
    logic [CAP_BITS-1:0] c;
    c = capf(a, b);
    return (c != '0) && (usage[{a, b}] < c);
  endfunction

  // candidate decode: cand 0 = direct, 1..4 = one hop m1, 5..20 = two hops
  always_comb begin
    m1 = '0;
    m2 = '0;
    len = 3'd2;
    if (cand == 5'd0) len = 3'd2;
    else if (cand < 5'd5) begin
      len = 3'd3;
      m1 = 2'(cand - 5'd1);
    end else begin
      len = 3'd4;
      m1 = 2'((cand - 5'd5) >> 2);
      m2 = 2'(cand - 5'd5);
    end
  end

  logic cand_free;
  always_comb begin
    priority case (len)
      3'd2: cand_free = link_ok(src, dst);
      3'd3: cand_free = m1 != src && m1 != dst && relf(m1) != NO_RELAY &&
                        link_ok(src, m1) && link_ok(m1, dst);
      default: cand_free = m1 != src && m1 != dst && m2 != src && m2 != dst &&
                           m1 != m2 && relf(m1) != NO_RELAY &&
                           relf(m2) != NO_RELAY && link_ok(src, m1) &&
                           link_ok(m1, m2) && link_ok(m2, dst);
    endcase
  end

  logic [2:0] lim;
  assign lim = (max_dies > 3'd4) ? 3'd4 : max_dies;

  logic in_range, last, found, fail;
  assign in_range = len <= lim;
  assign found = in_range && cand_free;
  assign last = (cand == 5'd20) || !in_range;
  assign fail = !in_range || (cand == 5'd20 && !cand_free);

  logic same_r, done_r;
  assign stat = {same_r, done_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      same_r <= 1'b0;
      done_r <= 1'b0;
      for (int i = 0; i < NL; i++) usage[i] <= '0;
    end else if (cmd.load) begin
      src <= in_src;
      dst <= in_dst;
      source_point <= 16'(in_s);
      dest_point <= 16'(in_l);
      cand <= '0;
      same_r <= in_src == in_dst;
      done_r <= !valid_die(in_src) || !valid_die(in_dst);
      status <= (in_src == in_dst) ? ST_SAME : ST_NO_PATH;
      path_length <= '0;
      second_die <= '0;
      third_die <= '0;
      fourth_die <= '0;
      first_relay <= '0;
      second_relay <= '0;
    end else if (cmd.step) begin
      if (found) begin
        done_r <= 1'b1;
        status <= ST_ROUTED;
        path_length <= len;
        second_die <= (len == 3'd2) ? dst : m1;
        third_die <= (len == 3'd3) ? dst : ((len == 3'd4) ? m2 : 2'd0);
        fourth_die <= (len == 3'd4) ? dst : 2'd0;
        first_relay <= (len != 3'd2) ? relf(m1) : '0;
        second_relay <= (len == 3'd4) ? relf(m2) : '0;
      end else if (fail || last) begin
        done_r <= 1'b1;
      end else begin
        cand <= cand + 5'd1;
      end
    end else if (cmd.commit) begin
      if (status == ST_ROUTED) begin
        usage[{src, second_die}] <= usage[{src, second_die}] + 1'b1;
        if (path_length >= 3'd3)
          usage[{second_die, third_die}] <= usage[{second_die, third_die}] + 1'b1;
        if (path_length == 3'd4)
          usage[{third_die, fourth_die}] <= usage[{third_die, fourth_die}] + 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/die_link_path_allocator.sv =====
// top level of the die link path allocator
// usage: a request beat on s_axis carries source and target die plus two
// point ids; one response beat on m_axis carries status, the chosen die
// sequence and relay ids. configuration is written through cfg_we /
// cfg_index / cfg_data; the user must write it only while the block is
// idle, the block itself does not enforce it.
// candidate paths are checked in turn (direct, up to four one-hop and
// sixteen two-hop candidates), the controller then sees the walk
// finish, and a commit state bumps the link usage counters.
// a request between equal dies skips the candidate walk and the commit.
// one request is handled at a time, with the sequential candidate walk
// in the datapath setting the pace.
// reset: capacities zero, all relays absent, path limit four, usage zero.
// stall: the response holds on m_axis until m_axis_tready; no new request
// is taken until then.
module die_link_path_allocator import dlpa_pkg::*; #(
  parameter int DIES       = DIES_DEF,
  parameter int POINT_BITS = POINT_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // src_die, dst_die, s_point_id, l_point_id, zero pad
  input  logic [2*POINT_BITS+7:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // status, source_point, dest_point, path_length, second_die, third_die,
  // fourth_die, first_relay, second_relay, zero pad
  output logic [79:0]              m_axis_tdata,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic [1:0]  status, d2, d3, d4;
  logic [15:0] sp, dp, r1, r2;
  logic [2:0]  plen;

  dlpa_ctrl u_ctrl (
    .clk, .rst,
    .in_fire  (s_axis_tvalid & s_axis_tready),
    .out_fire (m_axis_tvalid & m_axis_tready),
    .stat, .cmd,
    .in_ready (s_axis_tready),
    .out_valid(m_axis_tvalid)
  );

  dlpa_datapath #(.DIES(DIES), .POINT_BITS(POINT_BITS)) u_dp (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .cmd, .stat,
    .in_src (s_axis_tdata[1:0]),
    .in_dst (s_axis_tdata[3:2]),
    .in_s   (s_axis_tdata[4 +: POINT_BITS]),
    .in_l   (s_axis_tdata[4+POINT_BITS +: POINT_BITS]),
    .status, .source_point(sp), .dest_point(dp), .path_length(plen),
    .second_die(d2), .third_die(d3), .fourth_die(d4),
    .first_relay(r1), .second_relay(r2)
  );

  assign m_axis_tdata = {5'b0, r2, r1, d4, d3, d2, plen, dp, sp, status};

endmodule

// ===== sim/die_link_path_allocator_tb.sv =====
// testbench for die_link_path_allocator: path search, link usage and config checks
module die_link_path_allocator_tb import dlpa_pkg::*;;

  // last member sits in the lowest bits, matching the response beat layout
  typedef struct packed {
    logic [15:0] second_relay;
    logic [15:0] first_relay;
    logic [1:0]  fourth_die;
    logic [1:0]  third_die;
    logic [1:0]  second_die;
    logic [2:0]  path_length;
    logic [15:0] dest_point;
    logic [15:0] source_point;
    logic [1:0]  status;
  } grant_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  // src_die, dst_die, s_point_id, l_point_id, zero pad
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  // status, source_point, dest_point, path_length, second_die, third_die,
  // fourth_die, first_relay, second_relay, zero pad
  logic [79:0] m_axis_tdata;
  logic                     cfg_we = 0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  logic [63:0] link_cap_word [4];
  logic [63:0] relay_word;
  logic [2:0]  path_limit;
  logic [15:0] usage [16];

  grant_t grant_q[$];
  int errors = 0;
  int beats_sent = 0, beats_checked = 0, routed_cnt = 0, blocked_cnt = 0;
  int burst_left = 0;
  int hold_req = 0;
  int hold_left = 0;
  int rx_cycle = 0;

  die_link_path_allocator DUT (.*);

  always #4 clk = ~clk;

  function automatic logic [15:0] cap_of(int a, int b);
    if (a == b) return 16'd0;
    return link_cap_word[a][16*b +: 16];
  endfunction

  function automatic logic [15:0] relay_of(int d);
    return relay_word[16*d +: 16];
  endfunction

  function automatic bit link_free(int a, int b);
    return cap_of(a, b) != 0 && usage[a*4+b] < cap_of(a, b);
  endfunction

  function automatic bit hop_ok(int d);
    return relay_of(d) != NO_RELAY;
  endfunction

  // first free path, shortest first then lexicographic; bumps usage on grant
  function automatic grant_t allocate_path(logic [1:0] src, logic [1:0] dst,
                                           logic [15:0] sp, logic [15:0] lp);
    grant_t g;
    int lim;
    int hops [4];
    int n;
    n = 0;
    g = '0;
    g.source_point = sp;
    g.dest_point = lp;
    if (src == dst) begin
      g.status = ST_SAME;
      return g;
    end
    lim = (path_limit > 4) ? 4 : path_limit;
    hops[0] = src;
    if (lim >= 2 && link_free(src, dst)) n = 2;
    if (n == 0 && lim >= 3)
      for (int m = 0; m < 4 && n == 0; m++)
        if (m != src && m != dst && link_free(src, m) && hop_ok(m) && link_free(m, dst)) begin
          hops[1] = m;
          n = 3;
        end
    if (n == 0 && lim >= 4)
      for (int a = 0; a < 4 && n == 0; a++)
        for (int b = 0; b < 4 && n == 0; b++)
          if (a != src && a != dst && b != src && b != dst && a != b &&
              link_free(src, a) && hop_ok(a) && link_free(a, b) && hop_ok(b) &&
              link_free(b, dst)) begin
            hops[1] = a;
            hops[2] = b;
            n = 4;
          end
    if (n == 0) begin
      g.status = ST_NO_PATH;
      return g;
    end
    hops[n-1] = dst;
    for (int i = 0; i + 1 < n; i++) usage[hops[i]*4 + hops[i+1]]++;
    g.status = ST_ROUTED;
    g.path_length = 3'(n);
    g.second_die = 2'(hops[1]);
    if (n >= 3) begin
      g.third_die = 2'(hops[2]);
      g.first_relay = relay_of(hops[1]);
    end
    if (n >= 4) begin
      g.fourth_die = 2'(hops[3]);
      g.second_relay = relay_of(hops[2]);
    end
    return g;
  endfunction

  task automatic send_request(logic [1:0] src, logic [1:0] dst, logic [15:0] sp,
                              logic [15:0] lp);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    s_axis_tvalid <= 1;
    s_axis_tdata <= {4'b0, lp, sp, dst, src};
    do @(posedge clk); while (!s_axis_tready);
    grant_q = {grant_q, allocate_path(src, dst, sp, lp)};
    beats_sent++;
  endtask

  task automatic send_random_request();
    send_request(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), 16'($urandom),
                 16'($urandom));
  endtask

  // waits for the block to drain, then writes one register
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [63:0] val);
    @(negedge clk);
    s_axis_tvalid <= 0;
    wait (grant_q.size() == 0);
    repeat (30) @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    if (idx <= REG_CAP3) link_cap_word[idx[1:0]] = val;
    else if (idx == REG_RELAY) relay_word = val;
    else if (idx == REG_MAXP) path_limit = val[2:0];
  endtask

  function automatic logic [15:0] random_cap();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic logic [15:0] random_relay();
    case ($urandom_range(0, 4))
      0: return NO_RELAY;
      1: return 16'd0;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_reset_state();
    send_request(2'd0, 2'd0, 16'h0000, 16'hFFFF);
    send_request(2'd3, 2'd0, 16'hFFFF, 16'h0000);
    send_request(2'd1, 2'd2, 16'hA5A5, 16'h5A5A);
  endtask

  // ring 0->1->2->3->0 with self entries set, so they must be ignored
  task automatic test_ring_paths();
    write_reg(REG_CAP0, 64'h0000_0000_0002_FFFF);
    write_reg(REG_CAP0 + 3'd1, 64'h0000_0002_FFFF_0000);
    write_reg(REG_CAP0 + 3'd2, 64'h0003_FFFF_0000_0000);
    write_reg(REG_CAP3, 64'hFFFF_0000_0000_0001);
    write_reg(REG_RELAY, 64'h0003_0002_0001_0000);
    write_reg(REG_MAXP, 64'd4);
    send_request(2'd0, 2'd3, 16'h1234, 16'h4321);
    send_request(2'd1, 2'd3, 16'h0001, 16'h0002);
    send_request(2'd2, 2'd3, 16'hFFFF, 16'hFFFF);
    send_request(2'd3, 2'd1, 16'h0000, 16'h0000);
    send_request(2'd0, 2'd3, 16'h0101, 16'h0202);
    send_request(2'd0, 2'd3, 16'h0303, 16'h0404);
    send_request(2'd2, 2'd2, 16'h7777, 16'h8888);
  endtask

  task automatic test_path_limits();
    write_reg(REG_CAP0 + 3'd2, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_MAXP, 64'd1);
    send_request(2'd2, 2'd3, 16'h0011, 16'h0022);
    write_reg(REG_MAXP, 64'd0);
    send_request(2'd2, 2'd0, 16'h0033, 16'h0044);
    write_reg(REG_MAXP, 64'd7);
    send_request(2'd2, 2'd1, 16'h0055, 16'h0066);
    write_reg(REG_RELAY, 64'h0003_0002_FFFF_0000);
    send_request(2'd1, 2'd0, 16'h0077, 16'h0088);
    send_request(2'd2, 2'd0, 16'h0099, 16'h00AA);
  endtask

  task automatic test_random_traffic(int phases, int per_phase);
    for (int p = 0; p < phases; p++) begin
      for (int r = 0; r < 4; r++)
        write_reg(REG_CAP0 + 3'(r), {random_cap(), random_cap(), random_cap(), random_cap()});
      write_reg(REG_RELAY, {random_relay(), random_relay(), random_relay(), random_relay()});
      write_reg(REG_MAXP, 64'(($urandom_range(0, 2) == 0) ? $urandom_range(0, 7) : 4));
      repeat (per_phase) send_random_request();
    end
  endtask

  // receiver holds off while requests keep coming, so the input backs up
  task automatic test_output_backpressure();
    write_reg(REG_CAP0, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_CAP3, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_MAXP, 64'd4);
    hold_req = 400;
    repeat (20) send_random_request();
  endtask

  always @(negedge clk) begin
    rx_cycle++;
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 0;
    end else begin
      case ((rx_cycle / 300) % 4)
        0: m_axis_tready <= 1;
        1: m_axis_tready <= $urandom_range(0, 1);
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= ((rx_cycle % 7) < 4);
      endcase
    end
  end

  always @(posedge clk) begin
    grant_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[74:0];
      if (grant_q.size() == 0) begin
        $error("response beat with no request outstanding: %h", got);
        errors++;
      end else begin
        want = grant_q.pop_front();
        beats_checked++;
        if (want.status == ST_ROUTED) routed_cnt++;
        if (want.status == ST_NO_PATH) blocked_cnt++;
        if (got.status !== want.status) begin
          $error("status exp %0d got %0d", want.status, got.status); errors++; end
        if (got.source_point !== want.source_point) begin
          $error("source_point exp %h got %h", want.source_point, got.source_point);
          errors++; end
        if (got.dest_point !== want.dest_point) begin
          $error("dest_point exp %h got %h", want.dest_point, got.dest_point); errors++; end
        if (got.path_length !== want.path_length) begin
          $error("path_length exp %0d got %0d", want.path_length, got.path_length);
          errors++; end
        if (got.second_die !== want.second_die) begin
          $error("second_die exp %0d got %0d", want.second_die, got.second_die); errors++; end
        if (got.third_die !== want.third_die) begin
          $error("third_die exp %0d got %0d", want.third_die, got.third_die); errors++; end
        if (got.fourth_die !== want.fourth_die) begin
          $error("fourth_die exp %0d got %0d", want.fourth_die, got.fourth_die); errors++; end
        if (got.first_relay !== want.first_relay) begin
          $error("first_relay exp %h got %h", want.first_relay, got.first_relay); errors++; end
        if (got.second_relay !== want.second_relay) begin
          $error("second_relay exp %h got %h", want.second_relay, got.second_relay);
          errors++; end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d responses outstanding", grant_q.size());
    $display("FAIL");
    $finish;
  end

  initial begin
    for (int i = 0; i < 4; i++) link_cap_word[i] = '0;
    relay_word = '1;
    path_limit = 3'd4;
    for (int i = 0; i < 16; i++) usage[i] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    test_reset_state();
    test_ring_paths();
    test_path_limits();
    test_output_backpressure();
    test_random_traffic(8, 150);
    @(negedge clk);
    s_axis_tvalid <= 0;
    wait (grant_q.size() == 0);
    repeat (40) @(posedge clk);
    $display("%0d requests sent, %0d responses checked", beats_sent, beats_checked);
    $display("%0d routed, %0d refused for lack of a free path", routed_cnt, blocked_cnt);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
